>>> rtl/core/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

endpackage
`default_nettype wire

>>> rtl/core/sha256_ram.sv
`default_nettype none
module sha256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/sha256_message_digest_unit.sv
`default_nettype none
// Channel   Direction  Fields
// input     in         i_data_byte, i_has_byte, i_end_of_message (i_valid / o_stall)
// output    out        o_digest_word, o_word_index, o_last_word (o_valid / i_stall)
//
// A byte that fills a block starts its compression: the block is read from the
// RAM (64 reads plus the read latency) and runs 64 rounds, one round per cycle
// through the round logic, then a fold. End of message writes the padding one
// byte a cycle into the block RAM (into a second block if needed), each padded
// block is compressed as above, then come the eight digest transfers. Reset is
// synchronous and active low; the block RAM needs no clearing.
// The input stalls whenever a compression, padding or digest run is in progress.
module sha256_message_digest_unit
    import sha256_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    t_state      r_state, n_state;
    logic [60:0] r_count;
    logic [63:0] r_bits;
    logic        r_final;      // the block being compressed is the last one
    logic [6:0]  r_t;          // load byte counter, then round counter
    logic [5:0]  r_pad_pos;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [2:0]  r_emit;

    logic        ram_we;
    logic [5:0]  ram_waddr, ram_raddr;
    logic [7:0]  ram_wdata, ram_rdata;

    sha256_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic accept;
    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;

    // A byte that completes the block is compressed before any padding starts.
    logic block_full;
    assign block_full = i_has_byte && (r_count[5:0] == 6'd63);

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    // Message schedule and round function.
    logic [31:0] w_cur, w_new, s0, s1, t1, t2;
    assign s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + s0 + r_w[9] + s1;
    assign w_cur = r_w[0];
    assign t1 = r_v[7] + (ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + ROUND_K[r_t[5:0]] + w_cur;
    assign t2 = (ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    logic [63:0] end_bits;
    assign end_bits = {r_count + 61'(i_has_byte), 3'b000};

    logic [5:0] load_byte;
    logic [3:0] load_word;
    assign load_byte = r_t[5:0] - 6'd1;
    assign load_word = load_byte[5:2];

    // RAM port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[5:0];
        ram_wdata = i_data_byte;
        ram_raddr = r_t[5:0];
        unique case (r_state)
            ST_IDLE: begin
                ram_we = accept && i_has_byte;
            end
            ST_PAD: begin
                ram_we    = 1'b1;
                ram_waddr = r_pad_pos;
                if (r_final && r_pad_pos >= LEN_POS) begin
                    ram_wdata = r_bits[{~r_pad_pos[2:0], 3'b000} +: 8];
                end else if (r_pad_pos == r_count[5:0]) begin
                    ram_wdata = PAD_BYTE;
                end else begin
                    ram_wdata = 8'h00;
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (block_full) begin
                        n_state = ST_LOAD;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD:   if (r_pad_pos == 6'd63) n_state = ST_LOAD;
            ST_LOAD:  if (r_t == 7'd64) n_state = ST_ROUND;
            ST_ROUND: if (r_t == 7'd63) n_state = ST_FOLD;
            ST_FOLD:  n_state = r_final ? ST_EMIT : (r_pad_pos == 6'd0 && r_bits[0]
                                ? ST_PAD : ST_IDLE);
            ST_EMIT:  if (o_valid && !i_stall && r_emit == 3'd7) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign o_valid       = (r_state == ST_EMIT);
    assign o_digest_word = r_h[r_emit];
    assign o_word_index  = r_emit;
    assign o_last_word   = (r_emit == 3'd7);

    // r_bits[0] is never set by a real length (low three bits are zero), so it
    // marks that padding continues into a further block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_final   <= 1'b0;
            r_t       <= '0;
            r_pad_pos <= '0;
            r_emit    <= '0;
            r_bits    <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_H[i];
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_t <= '0;
                    if (accept) begin
                        if (i_has_byte) r_count <= r_count + 61'd1;
                        if (i_end_of_message) begin
                            r_bits <= {end_bits[63:1], block_full};
                            r_final <= ((end_bits[8:3] < LEN_POS - 6'd1) ||
                                        (end_bits[8:3] == LEN_POS - 6'd1)) && !block_full;
                            // pad starts at the byte after the data
                            r_pad_pos <= end_bits[8:3];
                        end else begin
                            r_final <= 1'b0;
                            r_pad_pos <= '0;
                        end
                    end
                end
                ST_PAD: begin
                    r_pad_pos <= r_pad_pos + 6'd1;
                    if (r_pad_pos == 6'd63) begin
                        r_t <= '0;
                        if (!r_final) begin
                            // the pad byte is placed; the next block holds zeros and length
                            r_bits[0]    <= 1'b1;
                            r_count[5:0] <= 6'd63;
                        end
                    end
                end
                ST_LOAD: begin
                    // registered read: byte t-1 arrives while t is addressed
                    if (r_t != 7'd0) begin
                        r_w[load_word] <= {r_w[load_word][23:0], ram_rdata};
                    end
                    if (r_t == 7'd64) begin
                        r_t <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end else begin
                        r_t <= r_t + 7'd1;
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_t <= r_t + 7'd1;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_t <= '0;
                    if (!r_final && r_bits[0]) begin
                        // last padding block: the length follows
                        r_bits[0]   <= 1'b0;
                        r_final     <= 1'b1;
                        r_pad_pos   <= '0;
                    end else begin
                        r_bits[0] <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (!i_stall) begin
                        r_emit <= r_emit + 3'd1;
                        if (r_emit == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= INIT_H[i];
                            r_count <= '0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    property p_no_emit_while_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> o_stall;
    endproperty
    a_no_emit_while_busy: assert property (p_no_emit_while_busy)
        else $error("digest shown while input open");

    property p_last_on_seven;
        @(posedge i_clk) disable iff (!i_rst_n) o_valid && o_last_word |-> o_word_index == 3'd7;
    endproperty
    a_last_on_seven: assert property (p_last_on_seven)
        else $error("last word flag misplaced");

    property p_round_leads_fold;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_state == ST_FOLD |-> $past(r_state) == ST_ROUND;
    endproperty
    a_round_leads_fold: assert property (p_round_leads_fold)
        else $error("fold without rounds");

endmodule
`default_nettype wire
